// File: design/rfrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfrc_pkg: shared types and constants of the rtu frame receive checker
// Frame limits, item kinds, verdict codes, queue sizing and the crc16 update.
// ----------------------------------------------------------------------------
package rfrc_pkg;

  localparam int MAX_FRAME = 256;
  localparam int MIN_FRAME = 4;
  // address byte plus two crc bytes
  localparam int FRAME_OVERHEAD = 3;
  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] OWN_ADDR_RST = 8'h01;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_TIMEOUT = 1'b1
  } op_kind_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_ADDR  = 3'd2,
    ST_CRC   = 3'd3,
    ST_OVF   = 3'd4
  } status_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [7:0]  data;
  } op_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

  // modbus crc16, one byte, reflected
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: design/rfrc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfrc_front: input side of the frame checker
// Accepts words, classifies them as data byte or frame timeout and holds
// them in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
module rfrc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [7:0]        rx_byte_i,
  output rfrc_pkg::q_head_t head_o,
  input  logic              pop_i
);
  import rfrc_pkg::*;

  op_t                mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               push;
  logic               pop;
  op_t                new_op;

  assign in_ready_o = (cnt_q != Q_CNT_W'(Q_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != '0);

  always_comb begin
    new_op.kind = func_i ? OP_TIMEOUT : OP_BYTE;
    // timeout words carry no byte
    new_op.data = func_i ? 8'h00 : rx_byte_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_op;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.op    = mem_q[rd_ptr_q];

endmodule

// File: design/rfrc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfrc_back: frame state and verdict
// Runs the byte count, address capture and crc16 per byte word and builds
// the verdict into an output register on a timeout word.
// ----------------------------------------------------------------------------
module rfrc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rfrc_pkg::q_head_t head_i,
  output logic              pop_o,
  input  logic [7:0]        own_address_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic              pdu_ok_o,
  output logic              is_broadcast_o,
  output logic [7:0]        pdu_length_o
);
  import rfrc_pkg::*;

  logic [15:0]      crc_q, crc_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       addr_q, addr_d;
  logic             ovf_q, ovf_d;
  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  logic             ok_q, ok_d;
  logic             bcast_q, bcast_d;
  logic [7:0]       plen_q, plen_d;
  logic             out_free;
  logic             take;
  logic             is_byte;

  assign is_byte  = (head_i.op.kind == OP_BYTE);
  assign out_free = !out_valid_q || out_ready_i;
  // byte words never wait on the output side
  assign take     = head_i.valid && (is_byte || out_free);
  assign pop_o    = take;

  always_comb begin
    status_d = status_q;
    if (ovf_q) begin
      status_d = ST_OVF;
    end else if (count_q < CNT_W'(MIN_FRAME)) begin
      status_d = ST_SHORT;
    end else if (addr_q != own_address_i && addr_q != 8'h00) begin
      status_d = ST_ADDR;
    end else if (crc_q != 16'h0000) begin
      status_d = ST_CRC;
    end else begin
      status_d = ST_OK;
    end
    ok_d    = (status_d == ST_OK);
    bcast_d = (count_q != '0) && (addr_q == 8'h00);
    plen_d  = ok_d ? 8'(count_q - CNT_W'(FRAME_OVERHEAD)) : 8'h00;
  end

  always_comb begin
    crc_d       = crc_q;
    count_d     = count_q;
    addr_d      = addr_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (take) begin
      if (is_byte) begin
        if (count_q == CNT_W'(MAX_FRAME)) begin
          ovf_d = 1'b1;
        end else begin
          if (count_q == '0) begin
            addr_d = head_i.op.data;
          end
          crc_d   = crc16_byte(crc_q, head_i.op.data);
          count_d = count_q + 1'b1;
        end
      end else begin
        out_valid_d = 1'b1;
        crc_d       = CRC_INIT;
        count_d     = '0;
        addr_d      = 8'h00;
        ovf_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CRC_INIT;
      count_q     <= '0;
      addr_q      <= 8'h00;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      count_q     <= count_d;
      addr_q      <= addr_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !is_byte) begin
      status_q <= status_d;
      ok_q     <= ok_d;
      bcast_q  <= bcast_d;
      plen_q   <= plen_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign pdu_ok_o       = ok_q;
  assign is_broadcast_o = bcast_q;
  assign pdu_length_o   = plen_q;

endmodule

// File: design/rtu_frame_receive_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtu_frame_receive_checker: modbus rtu receive frame checker
// Counts frame bytes, captures the address, runs crc16 and gives one verdict
// per inter-frame timeout word.
// ----------------------------------------------------------------------------
// throughput: one word per cycle (combinational byte crc update) unless a held
//   verdict stalls a timeout word and the input queue fills; a timeout word
//   passes through the 2-entry input queue, then its verdict loads the output
//   register; a verdict left waiting holds the next timeout word in the queue
// reset: asynchronous active low; clears queue, frame state, output valid,
//   and sets own_address to 1

module rtu_frame_receive_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic       pdu_ok_o,
  output logic       is_broadcast_o,
  output logic [7:0] pdu_length_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);
  import rfrc_pkg::*;

  logic [7:0] own_addr_q;
  q_head_t    head;
  logic       pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= OWN_ADDR_RST;
    end else if (cfg_we_i) begin
      own_addr_q <= cfg_wdata_i;
    end
  end

  rfrc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .rx_byte_i  (rx_byte_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  rfrc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .own_address_i  (own_addr_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .pdu_ok_o       (pdu_ok_o),
    .is_broadcast_o (is_broadcast_o),
    .pdu_length_o   (pdu_length_o)
  );

  // pdu_ok must agree with the verdict code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pdu_ok_o == (status_o == ST_OK)))
    else $error("pdu_ok disagrees with status");

  // pdu length only reported on good frames, and then at least the minimum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pdu_ok_o) |-> (pdu_length_o == 8'h00))
    else $error("pdu length on rejected frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pdu_ok_o) |-> (pdu_length_o >= 8'(MIN_FRAME - FRAME_OVERHEAD)))
    else $error("good frame shorter than minimum");

  // the back end never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("pop from empty queue");

endmodule
